// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the NFA string acceptor RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/core/nfa_sa_pkg.sv =====
// ---------------------------------------------------------------------------
// nfa_sa_pkg
// Shared types and codes of the NFA string acceptor.
// ---------------------------------------------------------------------------
package nfa_sa_pkg;

  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 1;

  // Item kinds carried in tuser
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SYMBOL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK = 1'b1;

  typedef struct packed {
    logic [3:0]  start_state;
    logic [15:0] accept_mask;
  } cfg_t;

  typedef struct packed {
    logic clearing;
    logic res_valid;
    logic accepted;
  } stat_t;

endpackage

// ===== rtl/core/nfa_sa_store.sv =====
// ---------------------------------------------------------------------------
// nfa_sa_store
// Single-port transition store with registered read data.
// ---------------------------------------------------------------------------
module nfa_sa_store #(
  parameter int WIDTH = 16,
  parameter int AW    = 12,
  parameter int DEPTH = 4096
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/core/nfa_sa_engine.sv =====
// ---------------------------------------------------------------------------
// nfa_sa_engine
// Sequencer that clears the store, loads entries, steps and tests the active set.
// ---------------------------------------------------------------------------
module nfa_sa_engine
  import nfa_sa_pkg::*;
#(
  parameter int NUM_STATES  = 16,
  parameter int SYMBOL_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] mode,
  input  logic [7:0]        symbol,
  input  logic [3:0]        from_state,
  input  logic [15:0]       next_set,
  input  cfg_t              cfg,
  input  logic              res_ready,
  output stat_t             stat
);

  localparam int SW    = (NUM_STATES > 2) ? $clog2(NUM_STATES) : 1;
  localparam int AW    = SW + SYMBOL_BITS;
  localparam int DEPTH = NUM_STATES << SYMBOL_BITS;
  localparam int NW    = (NUM_STATES > 16) ? NUM_STATES : 16;
  localparam int FW    = (SW > 4) ? SW : 4;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]             state;
  logic [AW-1:0]          clr_addr;
  logic [SW-1:0]          cnt;
  logic [NUM_STATES-1:0]  scan_set;
  logic [SYMBOL_BITS-1:0] sym_reg;
  logic [NUM_STATES-1:0]  acc;
  logic [NUM_STATES-1:0]  acc_next;
  logic                   rd_pend;
  logic                   rd_bit;
  logic [NUM_STATES-1:0]  active;
  logic                   in_string;
  logic                   fin_hit;

  logic [NUM_STATES-1:0]  start_set;
  logic [NUM_STATES-1:0]  cur_set;
  logic [NW-1:0]          next_ext;
  logic [NW-1:0]          mask_ext;
  logic [FW-1:0]          from_ext;
  logic                   load_ok;

  logic                   st_we;
  logic [AW-1:0]          st_addr;
  logic [NUM_STATES-1:0]  st_wdata;
  logic [NUM_STATES-1:0]  st_rdata;

  assign in_ready  = (state == ST_IDLE);
  assign start_set = {{(NUM_STATES-1){1'b0}}, 1'b1} << cfg.start_state;
  assign cur_set   = in_string ? active : start_set;
  assign next_ext  = NW'(next_set);
  assign mask_ext  = NW'(cfg.accept_mask);
  assign from_ext  = FW'(from_state);
  assign load_ok   = (int'(from_state) < NUM_STATES);
  assign acc_next  = acc | ((rd_pend && rd_bit) ? st_rdata : '0);

  assign stat.clearing  = (state == ST_CLEAR);
  assign stat.res_valid = (state == ST_FIN);
  assign stat.accepted  = fin_hit;

  // Store port: clear sweep, load write, or scan read
  always_comb begin
    st_we    = 1'b0;
    st_addr  = {cnt, sym_reg};
    st_wdata = next_ext[NUM_STATES-1:0];
    unique case (state)
      ST_CLEAR: begin
        st_we    = 1'b1;
        st_addr  = clr_addr;
        st_wdata = '0;
      end
      ST_IDLE: begin
        st_we   = in_valid && (mode == MODE_LOAD) && load_ok;
        st_addr = {from_ext[SW-1:0], symbol[SYMBOL_BITS-1:0]};
      end
      default: begin
        st_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      in_string <= 1'b0;
      active    <= '0;
      rd_pend   <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            if (mode == MODE_SYMBOL) begin
              scan_set <= cur_set;
              sym_reg  <= symbol[SYMBOL_BITS-1:0];
              acc      <= '0;
              cnt      <= '0;
              state    <= ST_SCAN;
            end else if (mode == MODE_FINISH) begin
              fin_hit   <= |(cur_set & mask_ext[NUM_STATES-1:0]);
              in_string <= 1'b0;
              active    <= '0;
              state     <= ST_FIN;
            end
          end
        end
        ST_SCAN: begin
          // issue one read per state, fold the previous read into the set
          acc     <= acc_next;
          rd_pend <= 1'b1;
          rd_bit  <= scan_set[cnt];
          cnt     <= cnt + 1'b1;
          if (cnt == SW'(NUM_STATES - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          active    <= acc_next;
          in_string <= 1'b1;
          rd_pend   <= 1'b0;
          state     <= ST_IDLE;
        end
        ST_FIN: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  nfa_sa_store #(
    .WIDTH (NUM_STATES),
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .addr  (st_addr),
    .wdata (st_wdata),
    .rdata (st_rdata)
  );

endmodule

// ===== rtl/core/nfa_string_acceptor_top.sv =====
// ---------------------------------------------------------------------------
// nfa_string_acceptor_top
// NFA string acceptor: bit-set simulation over a loadable transition store.
// ---------------------------------------------------------------------------
// Input items arrive on s_*; s_tuser carries the kind (load entry, symbol,
// finish). A load writes one (state, symbol) successor set. A symbol item
// walks all NUM_STATES states through the single store port, one read per
// cycle, ORing the successor sets of active states: the block stays busy
// through the scan and drain states after it is taken. A finish item goes to
// the finish state, then its result to the m_* output register when free;
// nothing else gives a result. s_tready is low while an item is in work.
// The output register holds a result until m_tready; the next input item
// is still taken meanwhile, and a second finish waits in the engine.
// Configuration writes (start_state, accept_mask) on cfg_* are always
// ready and are meant for idle periods only.
// After rst the store is swept to all zeros, one entry per cycle, over all
// NUM_STATES << SYMBOL_BITS entries (4096 by default); s_tready stays
// low meanwhile. Reset also ends any string and clears both registers.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nfa_string_acceptor_top
  import nfa_sa_pkg::*;
#(
  parameter int NUM_STATES  = 16,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,    // symbol[7:0], from_state[11:8], next_set[27:12]
  input  logic [MODE_W-1:0]    s_tuser,    // mode[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,    // accepted[0]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_t  cfg;
  stat_t stat;
  logic  res_ready;
  logic  accepted;
  logic  in_take;

  assign cfg_ready = 1'b1;
  assign res_ready = !m_tvalid || m_tready;
  assign m_tdata   = {7'b0, accepted};
  assign in_take   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_state <= '0;
      cfg.accept_mask <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_STATE: cfg.start_state <= cfg_data[3:0];
        CFG_ACCEPT_MASK: cfg.accept_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output register: load a new result when it is empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (stat.res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.res_valid && res_ready) begin
      accepted <= stat.accepted;
    end
  end

  nfa_sa_engine #(
    .NUM_STATES  (NUM_STATES),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .mode       (s_tuser),
    .symbol     (s_tdata[7:0]),
    .from_state (s_tdata[11:8]),
    .next_set   (s_tdata[27:12]),
    .cfg        (cfg),
    .res_ready  (res_ready),
    .stat       (stat)
  );

  `ASSERT_IMPLY(a_no_item_in_clear, clk, rst, stat.clearing, !s_tready)
  `ASSERT_NEXT(a_symbol_busy, clk, rst, in_take && (s_tuser == MODE_SYMBOL), !s_tready)
  `ASSERT_NEXT(a_finish_busy, clk, rst, in_take && (s_tuser == MODE_FINISH), stat.res_valid)
  `ASSERT_NEXT(a_result_lands, clk, rst, stat.res_valid && res_ready, m_tvalid && !stat.res_valid)

endmodule
